@@ rtl/core/esd_pkg.sv @@
// Shared types and constants for the escape sequence decoder.
// No dependencies; every other file of the block but esd_if imports this package.
`default_nettype none

package esd_pkg;

    // Per item the decoder can raise at most four results
    localparam int MAX_RES = 4;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_DIG1,
        PH_DIG2,
        PH_HEX,
        PH_HEXLO,
        PH_GRP,
        PH_GRPLO
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_INCOMPLETE_ESC,
        ERR_INVALID_OCTAL,
        ERR_OCTAL_RANGE,
        ERR_INCOMPLETE_HEX,
        ERR_INVALID_HEX,
        ERR_UNCLOSED_GROUP
    } err_t;

    // One result as it leaves the block (last_of_item is added by the back end)
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] error_code;
        logic       end_of_string;
    } ent_t;

    // All results caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        ent_t [MAX_RES-1:0]       ent;
    } job_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/esd_if.sv @@
// Channel interfaces of the escape sequence decoder: input, output, config.
// Depends on nothing; payload widths follow the field list of the block.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] error_code;
    logic       end_of_string;
    logic       last_of_item;

    modport source (output valid, output out_byte, output has_byte, output error_code,
                    output end_of_string, output last_of_item, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input error_code,
                    input end_of_string, input last_of_item, output ready);
endinterface

interface esd_cfg_if;
    logic valid;
    logic ready;
    logic wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/escape_sequence_decoder_unit.sv @@
// Top level of the escape sequence decoder: config register, front, queue, back.
// Depends on esd_pkg, esd_if, esd_front, esd_queue and esd_back.
//
//  channel   dir  payload                                             accepted when
//  in_chan   in   in_byte[7:0], in_last                               valid && ready
//  out_chan  out  out_byte[7:0], has_byte, error_code[2:0],
//                 end_of_string, last_of_item                         valid && ready
//  cfg_chan  in   wdata (strip_all)                                   valid && ready
//
// One input item is taken per cycle while the job queue has room; the zero to
// four results of an item are built as it is accepted and queued as one job if any.
// Results leave one per cycle from the back end while out_chan is ready, so an
// item with more than one result holds the output until each is taken; the
// four-entry queue absorbs it. A result is written into a queue slot and then
// loaded into the back end's current-job register before it is offered.
// rst_n clears phase, discard flag, queue pointers and strip_all; no clearing pass.
// A stalled output fills the queue, after which in_chan.ready falls.
`default_nettype none

module escape_sequence_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    esd_in_if.sink     in_chan,
    esd_out_if.source  out_chan,
    esd_cfg_if.sink    cfg_chan
);
    import esd_pkg::*;

    logic    strip_all_reg, strip_all_next;
    logic    push;
    logic    pop;
    job_t    wr_job;
    job_t    head;
    q_stat_t q_stat;

    // configuration is always accepted; it is to be written only while idle, which the block does not enforce
    assign cfg_chan.ready = 1'b1;
    assign strip_all_next = (cfg_chan.valid && cfg_chan.ready) ? cfg_chan.wdata
                                                              : strip_all_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_all_reg <= 1'b0;
        end
        else
        begin
            strip_all_reg <= strip_all_next;
        end
    end

    // classify and decode each item, tracking escape phase
    esd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .strip_all (strip_all_reg),
        .q_stat    (q_stat),
        .push      (push),
        .job       (wr_job)
    );

    // decouples the per-item front from the per-result back
    esd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // serialise each job onto the output channel
    esd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_chan (out_chan)
    );

endmodule

`default_nettype wire

@@ rtl/core/esd_front.sv @@
// Front end: accepts input items, tracks the escape phase, builds result jobs.
// Depends on esd_pkg and esd_in_if.
`default_nettype none

module esd_front (
    input  logic              clk,
    input  logic              rst_n,
    esd_in_if.sink            in_chan,
    input  logic              strip_all,
    input  esd_pkg::q_stat_t  q_stat,
    output logic              push,
    output esd_pkg::job_t     job
);
    import esd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_first_reg, held_first_next;
    logic [7:0] held_second_reg, held_second_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       disc_reg, disc_next;

    logic       accept;
    logic       failed;
    logic [7:0] b;
    logic       last;
    logic       is_dec;
    logic       hex_ok;
    logic [3:0] hex_nib;
    logic       bs_cont;

    function automatic job_t push_ent(job_t j, ent_t e);
        j.ent[j.cnt[RES_IW-1:0]] = e;
        j.cnt = j.cnt + CNT_W'(1);
        return j;
    endfunction

    function automatic job_t push_byte(job_t j, logic [7:0] v);
        ent_t e;
        e.out_byte      = v;
        e.has_byte      = 1'b1;
        e.error_code    = ERR_NONE;
        e.end_of_string = 1'b0;
        return push_ent(j, e);
    endfunction

    function automatic job_t push_err(job_t j, err_t code);
        ent_t e;
        e.out_byte      = 8'd0;
        e.has_byte      = 1'b0;
        e.error_code    = code;
        e.end_of_string = 1'b1;
        return push_ent(j, e);
    endfunction

    assign b       = in_chan.in_byte;
    assign last    = in_chan.in_last;
    assign accept  = in_chan.valid && in_chan.ready;
    assign is_dec  = (b >= CH_0) && (b <= CH_9);
    assign bs_cont = (b == CH_BSLASH) && !last;

    // hex digit value; letters map through their low nibble plus nine
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_nib = b[3:0];
        if ((b >= CH_0) && (b <= CH_9))
        begin
            hex_nib = b[3:0];
        end
        else if (((b >= CH_LA) && (b <= CH_LF)) || ((b >= CH_UA) && (b <= CH_UF)))
        begin
            hex_nib = b[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign in_chan.ready = !q_stat.full;
    assign push          = accept && (job.cnt != '0);

    // results of the current item
    always_comb
    begin
        job_t j;
        j      = '0;
        failed = 1'b0;
        if (!disc_reg)
        begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    if (b == CH_BSLASH)
                    begin
                        if (!strip_all) j = push_byte(j, CH_BSLASH);
                        j = push_byte(j, CH_BSLASH);
                    end
                    else if (b == CH_N) j = push_byte(j, CH_NL);
                    else if (b == CH_T) j = push_byte(j, CH_TAB);
                    else if (b == CH_R) j = push_byte(j, CH_CR);
                    else if (b == CH_X)
                    begin
                        if (last)
                        begin
                            j      = push_err(j, ERR_INCOMPLETE_HEX);
                            failed = 1'b1;
                        end
                    end
                    else if (!(is_dec && !last))
                    begin
                        if (!strip_all) j = push_byte(j, CH_BSLASH);
                        j = push_byte(j, b);
                    end
                end
                PH_DIG1:
                begin
                    if (!(is_dec && !last))
                    begin
                        if (!strip_all) j = push_byte(j, CH_BSLASH);
                        j = push_byte(j, held_first_reg);
                        if (b != CH_BSLASH) j = push_byte(j, b);
                        else if (last)
                        begin
                            j      = push_err(j, ERR_INCOMPLETE_ESC);
                            failed = 1'b1;
                        end
                    end
                end
                PH_DIG2:
                begin
                    if (is_dec)
                    begin
                        if ((held_first_reg > CH_7) || (held_second_reg > CH_7) || (b > CH_7))
                        begin
                            j      = push_err(j, ERR_INVALID_OCTAL);
                            failed = 1'b1;
                        end
                        else if (held_first_reg > CH_3)
                        begin
                            j      = push_err(j, ERR_OCTAL_RANGE);
                            failed = 1'b1;
                        end
                        else
                        begin
                            j = push_byte(j, {held_first_reg[1:0], held_second_reg[2:0],
                                              b[2:0]});
                        end
                    end
                    else
                    begin
                        if (!strip_all) j = push_byte(j, CH_BSLASH);
                        j = push_byte(j, held_first_reg);
                        j = push_byte(j, held_second_reg);
                        if (b != CH_BSLASH) j = push_byte(j, b);
                        else if (last)
                        begin
                            j      = push_err(j, ERR_INCOMPLETE_ESC);
                            failed = 1'b1;
                        end
                    end
                end
                PH_HEX, PH_GRP:
                begin
                    if ((phase_reg == PH_HEX) && (b == CH_LBRACE))
                    begin
                        if (last)
                        begin
                            j      = push_err(j, ERR_UNCLOSED_GROUP);
                            failed = 1'b1;
                        end
                    end
                    else if (!((phase_reg == PH_GRP) && (b == CH_RBRACE)))
                    begin
                        if (last)
                        begin
                            j      = push_err(j, ERR_INCOMPLETE_HEX);
                            failed = 1'b1;
                        end
                        else if (!hex_ok)
                        begin
                            j      = push_err(j, ERR_INVALID_HEX);
                            failed = 1'b1;
                        end
                    end
                end
                PH_HEXLO, PH_GRPLO:
                begin
                    if (!hex_ok)
                    begin
                        j      = push_err(j, ERR_INVALID_HEX);
                        failed = 1'b1;
                    end
                    else
                    begin
                        j = push_byte(j, {nibble_reg, hex_nib});
                        if ((phase_reg == PH_GRPLO) && last)
                        begin
                            j      = push_err(j, ERR_UNCLOSED_GROUP);
                            failed = 1'b1;
                        end
                    end
                end
                PH_TEXT:
                begin
                    if (b != CH_BSLASH) j = push_byte(j, b);
                    else if (last)
                    begin
                        j      = push_err(j, ERR_INCOMPLETE_ESC);
                        failed = 1'b1;
                    end
                end
            endcase
            if (last)
            begin
                // a final byte that decodes to nothing still closes the string
                if (j.cnt == '0) j = push_err(j, ERR_NONE);
                j.ent[RES_IW'(j.cnt - CNT_W'(1))].end_of_string = 1'b1;
            end
        end
        job = j;
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        nibble_next      = nibble_reg;
        disc_next        = disc_reg;
        if (accept)
        begin
            if (disc_reg)
            begin
                if (last)
                begin
                    disc_next  = 1'b0;
                    phase_next = PH_TEXT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_ESC:
                    begin
                        phase_next = PH_TEXT;
                        if ((b == CH_X) && !last) phase_next = PH_HEX;
                        else if (is_dec && !last)
                        begin
                            held_first_next = b;
                            phase_next      = PH_DIG1;
                        end
                    end
                    PH_DIG1:
                    begin
                        if (is_dec && !last)
                        begin
                            held_second_next = b;
                            phase_next       = PH_DIG2;
                        end
                        else phase_next = bs_cont ? PH_ESC : PH_TEXT;
                    end
                    PH_DIG2:
                    begin
                        phase_next = (!is_dec && bs_cont) ? PH_ESC : PH_TEXT;
                    end
                    PH_HEX, PH_GRP:
                    begin
                        phase_next = PH_TEXT;
                        if ((phase_reg == PH_HEX) && (b == CH_LBRACE))
                        begin
                            if (!last) phase_next = PH_GRP;
                        end
                        else if (!((phase_reg == PH_GRP) && (b == CH_RBRACE)))
                        begin
                            if (!last && hex_ok)
                            begin
                                nibble_next = hex_nib;
                                phase_next  = (phase_reg == PH_HEX) ? PH_HEXLO : PH_GRPLO;
                            end
                        end
                    end
                    PH_HEXLO:
                    begin
                        phase_next = PH_TEXT;
                    end
                    PH_GRPLO:
                    begin
                        phase_next = (hex_ok && !last) ? PH_GRP : PH_TEXT;
                    end
                    PH_TEXT:
                    begin
                        phase_next = bs_cont ? PH_ESC : PH_TEXT;
                    end
                endcase
                if (last) phase_next = PH_TEXT;
                if (failed && !last) disc_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TEXT;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            nibble_reg      <= '0;
            disc_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            nibble_reg      <= nibble_next;
            disc_reg        <= disc_next;
        end
    end

`ifndef ASSERT_OFF
    // a final byte always leaves the decoder in plain text, not discarding
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (phase_reg == PH_TEXT) && !disc_reg)
        else $error("phase not restored after final byte");
    // a final byte outside discard always yields a result closing the string
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last && !disc_reg) |-> push)
        else $error("final byte produced no result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/esd_queue.sv @@
// Short job queue between the front and back ends of the decoder.
// Depends on esd_pkg.
`default_nettype none

module esd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  esd_pkg::job_t     wr_job,
    input  logic              pop,
    output esd_pkg::job_t     head,
    output esd_pkg::q_stat_t  q_stat
);
    import esd_pkg::*;

    job_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCW'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + QCW'(1);
        else if (pop && !push) count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full) && !(pop && q_stat.empty))
        else $error("job queue overflow or underflow");
`endif

endmodule

`default_nettype wire

@@ rtl/core/esd_back.sv @@
// Back end: takes jobs from the queue and hands out their results one a cycle while the output is ready.
// Depends on esd_pkg and esd_out_if.
`default_nettype none

module esd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  esd_pkg::job_t     head,
    input  esd_pkg::q_stat_t  q_stat,
    output logic              pop,
    esd_out_if.source         out_chan
);
    import esd_pkg::*;

    job_t              cur_reg, cur_next;
    logic [RES_IW-1:0] idx_reg, idx_next;
    logic              busy_reg, busy_next;

    logic take;
    logic done;
    ent_t ent;

    assign take = busy_reg && out_chan.ready;
    assign done = take && ({1'b0, idx_reg} == CNT_W'(cur_reg.cnt - CNT_W'(1)));
    assign pop  = (!busy_reg || done) && !q_stat.empty;

    always_comb
    begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            cur_next  = head;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + RES_IW'(1);
        end
    end

    assign ent                    = cur_reg.ent[idx_reg];
    assign out_chan.valid         = busy_reg;
    assign out_chan.out_byte      = ent.out_byte;
    assign out_chan.has_byte      = ent.has_byte;
    assign out_chan.error_code    = ent.error_code;
    assign out_chan.end_of_string = ent.end_of_string;
    assign out_chan.last_of_item  = ({1'b0, idx_reg} == CNT_W'(cur_reg.cnt - CNT_W'(1)));

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_reg.cnt != '0) && ({1'b0, idx_reg} < cur_reg.cnt))
        else $error("result index beyond job");
`endif

endmodule

`default_nettype wire
